// ===== rtl/core/fbit_pkg.sv =====
`default_nettype none

package fbit_pkg;

	// Number of selectable presets and the preset used after reset
	localparam int unsigned PRESET_COUNT   = 9;
	localparam int unsigned DEFAULT_PRESET = 4;

	// Saturation limits of the remaining-seconds fields
	localparam int unsigned FOCUS_CAP = 5400;
	localparam int unsigned BREAK_CAP = 1800;

	// Millisecond and second constants
	localparam int unsigned MS_PER_SEC   = 1000;
	localparam int unsigned CEIL_ADJ     = MS_PER_SEC - 1;
	localparam int unsigned SEC_PER_MIN  = 60;
	localparam int unsigned FOCUS_CAP_MS = FOCUS_CAP * MS_PER_SEC;

	// x / 1000 == (x >> 3) / 125; reciprocal of 125 scaled by 2^27, rounded up
	localparam int unsigned RECIP_SHIFT = 27;
	localparam int unsigned RECIP_125   = 1073742;

	// Focus length thresholds for the break length choice
	localparam int unsigned LONG_FOCUS_SECS = 60 * SEC_PER_MIN;
	localparam int unsigned MID_FOCUS_SECS  = 30 * SEC_PER_MIN;

	// Reset values
	localparam logic [12:0] FOCUS_RESET_SECS = 13'd1500;
	localparam logic [4:0]  BREAK_MIN_RESET  = 5'd5;
	localparam logic [15:0] CONFIRM_WIN_RESET = 16'd5000;
	localparam logic [15:0] REWARD_WIN_RESET  = 16'd3000;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_FRUN    = 3'd1,
		MODE_FPAUSE  = 3'd2,
		MODE_CONFIRM = 3'd3,
		MODE_REWARD  = 3'd4,
		MODE_PROMPT  = 3'd5,
		MODE_BRUN    = 3'd6,
		MODE_BPAUSE  = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		CMD_TICK        = 4'd0,
		CMD_NEXT_PRESET = 4'd1,
		CMD_PREV_PRESET = 4'd2,
		CMD_START_FOCUS = 4'd3,
		CMD_PAUSE       = 4'd4,
		CMD_RESUME      = 4'd5,
		CMD_REQ_ABANDON = 4'd6,
		CMD_CANCEL_AB   = 4'd7,
		CMD_CONFIRM_AB  = 4'd8,
		CMD_START_BREAK = 4'd9,
		CMD_SKIP_BREAK  = 4'd10
	} cmd_t;

	typedef enum logic [2:0] {
		EV_NONE            = 3'd0,
		EV_FOCUS_DONE      = 3'd1,
		EV_REWARD_DONE     = 3'd2,
		EV_BREAK_DONE      = 3'd3,
		EV_CONFIRM_TIMEOUT = 3'd4
	} event_t;

	// Configuration register indexes
	localparam logic REG_CONFIRM_WIN = 1'b0;
	localparam logic REG_REWARD_WIN  = 1'b1;

	// Architectural state; one deadline serves run, confirm and reward phases,
	// since only one of them is live in any mode
	typedef struct packed {
		mode_t       mode;
		logic [3:0]  preset;
		logic [12:0] focus_left;
		logic [10:0] break_left;
		logic [4:0]  break_min;
		logic [1:0]  round;
		logic [31:0] session;
		logic [47:0] deadline;
	} fbit_state_t;

	localparam fbit_state_t STATE_RESET = '{
		mode:       MODE_IDLE,
		preset:     4'(DEFAULT_PRESET),
		focus_left: FOCUS_RESET_SECS,
		break_left: 11'd0,
		break_min:  BREAK_MIN_RESET,
		round:      2'd0,
		session:    32'd0,
		deadline:   48'd0
	};

	// Focus length in seconds of a preset; out-of-range presets use the default
	function automatic logic [12:0] preset_secs(input logic [3:0] idx);
		logic [3:0] i;
		logic [12:0] s;
		i = ({1'b0, idx} >= 5'(PRESET_COUNT)) ? 4'(DEFAULT_PRESET) : idx;
		case (i)
			4'd0:    s = 13'd300;
			4'd1:    s = 13'd600;
			4'd2:    s = 13'd900;
			4'd3:    s = 13'd1200;
			4'd4:    s = 13'd1500;
			4'd5:    s = 13'd1800;
			4'd6:    s = 13'd2700;
			4'd7:    s = 13'd3600;
			default: s = 13'd5400;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fbit_secs.sv =====
`default_nettype none

module fbit_secs import fbit_pkg::*; (
	input  wire logic [47:0] deadline,
	input  wire logic [47:0] now_ms,
	input  wire logic        sel_break,
	output logic             done,
	output logic [12:0]      secs
);

	logic [47:0] diff;
	logic        over;
	logic [22:0] adj;
	logic [40:0] prod;
	logic [12:0] quot;
	logic [12:0] cap;

	// Compare and take the distance to the deadline
	assign done = (now_ms >= deadline);
	assign diff = deadline - now_ms;
	assign over = (diff > 48'(FOCUS_CAP_MS));

	// Ceiling divide by 1000 through the reciprocal of 125 on the low bits
	assign adj  = diff[22:0] + 23'(CEIL_ADJ);
	assign prod = 41'(adj[22:3]) * 41'(RECIP_125);
	assign quot = prod[RECIP_SHIFT+12:RECIP_SHIFT];

	// Saturate at the cap of the running phase
	assign cap = sel_break ? 13'(BREAK_CAP) : 13'(FOCUS_CAP);

	always_comb begin
		if (done) begin
			secs = 13'd0;
		end else if (over || (quot > cap)) begin
			secs = cap;
		end else begin
			secs = quot;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fbit_step.sv =====
`default_nettype none

module fbit_step import fbit_pkg::*; (
	input  wire fbit_state_t  cur,
	input  wire logic [3:0]   cmd,
	input  wire logic [47:0]  now_ms,
	input  wire logic [15:0]  confirm_win,
	input  wire logic [15:0]  reward_win,
	output fbit_state_t       nxt,
	output logic              accepted,
	output logic [2:0]        event_res
);

	cmd_t        c;
	logic        done;
	logic [12:0] run_secs;
	logic [12:0] sel_secs;
	logic [15:0] win;
	logic        use_win;
	logic [22:0] dur_ms;
	logic [48:0] sum;
	logic [47:0] new_dl;
	logic [12:0] cur_psecs;
	logic [10:0] brk_secs;
	logic [4:0]  inc_preset;
	logic [3:0]  p_next;
	logic [4:0]  bm;

	assign c = cmd_t'(cmd);

	fbit_secs u_secs (
		.deadline  (cur.deadline),
		.now_ms    (now_ms),
		.sel_break (cur.mode == MODE_BRUN),
		.done      (done),
		.secs      (run_secs)
	);

	assign cur_psecs = preset_secs(cur.preset);
	assign brk_secs  = 11'({6'd0, cur.break_min} * 11'(SEC_PER_MIN));

	// Pick the duration that a new deadline is built from
	always_comb begin
		sel_secs = cur_psecs;
		win      = reward_win;
		use_win  = 1'b0;
		case (c)
			CMD_TICK: begin
				use_win = 1'b1;
			end
			CMD_REQ_ABANDON: begin
				win     = confirm_win;
				use_win = 1'b1;
			end
			CMD_RESUME: begin
				sel_secs = (cur.mode == MODE_FPAUSE) ? cur.focus_left : {2'd0, cur.break_left};
			end
			CMD_START_BREAK: begin
				sel_secs = {2'd0, brk_secs};
			end
			default: begin
				sel_secs = cur_psecs;
			end
		endcase
	end

	// Add to now and saturate at the top of the time range
	assign dur_ms = use_win ? {7'd0, win} : (23'(sel_secs) * 23'(MS_PER_SEC));
	assign sum    = {1'b0, now_ms} + {26'd0, dur_ms};
	assign new_dl = sum[48] ? {48{1'b1}} : sum[47:0];

	// Wrap the preset index at both ends
	assign inc_preset = {1'b0, cur.preset} + 5'd1;
	always_comb begin
		if (c == CMD_NEXT_PRESET) begin
			p_next = (inc_preset >= 5'(PRESET_COUNT)) ? 4'd0 : inc_preset[3:0];
		end else begin
			p_next = (cur.preset == 4'd0) ? 4'(PRESET_COUNT - 1) : cur.preset - 4'd1;
		end
	end

	// Break length after a finished focus round
	always_comb begin
		if (cur_psecs >= 13'(LONG_FOCUS_SECS)) begin
			bm = 5'd15;
		end else if (cur_psecs >= 13'(MID_FOCUS_SECS)) begin
			bm = 5'd10;
		end else begin
			bm = 5'd5;
		end
		if (cur.round == 2'd3) begin
			bm = {bm[3:0], 1'b0};
		end
	end

	// Next state, acceptance and event
	always_comb begin
		nxt       = cur;
		accepted  = 1'b0;
		event_res = EV_NONE;
		case (c)
			CMD_TICK: begin
				accepted = 1'b1;
				case (cur.mode)
					MODE_FRUN: begin
						nxt.focus_left = run_secs;
						if (done) begin
							nxt.break_min = bm;
							nxt.round     = cur.round + 2'd1;
							nxt.mode      = MODE_REWARD;
							nxt.deadline  = new_dl;
							event_res     = EV_FOCUS_DONE;
						end
					end
					MODE_REWARD: begin
						if (done) begin
							nxt.mode  = MODE_PROMPT;
							event_res = EV_REWARD_DONE;
						end
					end
					MODE_BRUN: begin
						nxt.break_left = run_secs[10:0];
						if (done) begin
							nxt.mode       = MODE_IDLE;
							nxt.focus_left = cur_psecs;
							event_res      = EV_BREAK_DONE;
						end
					end
					MODE_CONFIRM: begin
						if (done) begin
							nxt.mode  = MODE_FPAUSE;
							event_res = EV_CONFIRM_TIMEOUT;
						end
					end
					default: begin
						event_res = EV_NONE;
					end
				endcase
			end
			CMD_NEXT_PRESET, CMD_PREV_PRESET: begin
				if (cur.mode == MODE_IDLE) begin
					nxt.preset     = p_next;
					nxt.focus_left = preset_secs(p_next);
					accepted       = 1'b1;
				end
			end
			CMD_START_FOCUS: begin
				if (cur.mode == MODE_IDLE) begin
					nxt.focus_left = cur_psecs;
					nxt.session    = cur.session + 32'd1;
					nxt.deadline   = new_dl;
					nxt.mode       = MODE_FRUN;
					accepted       = 1'b1;
				end
			end
			CMD_PAUSE: begin
				if (cur.mode == MODE_FRUN) begin
					nxt.focus_left = run_secs;
					nxt.mode       = MODE_FPAUSE;
					accepted       = 1'b1;
				end else if (cur.mode == MODE_BRUN) begin
					nxt.break_left = run_secs[10:0];
					nxt.mode       = MODE_BPAUSE;
					accepted       = 1'b1;
				end
			end
			CMD_RESUME: begin
				if (cur.mode == MODE_FPAUSE && cur.focus_left != 13'd0) begin
					nxt.mode     = MODE_FRUN;
					nxt.deadline = new_dl;
					accepted     = 1'b1;
				end else if (cur.mode == MODE_BPAUSE && cur.break_left != 11'd0) begin
					nxt.mode     = MODE_BRUN;
					nxt.deadline = new_dl;
					accepted     = 1'b1;
				end
			end
			CMD_REQ_ABANDON: begin
				if (cur.mode == MODE_FPAUSE) begin
					nxt.mode     = MODE_CONFIRM;
					nxt.deadline = new_dl;
					accepted     = 1'b1;
				end
			end
			CMD_CANCEL_AB: begin
				if (cur.mode == MODE_CONFIRM) begin
					nxt.mode = MODE_FPAUSE;
					accepted = 1'b1;
				end
			end
			CMD_CONFIRM_AB: begin
				if (cur.mode == MODE_CONFIRM) begin
					nxt.mode       = MODE_IDLE;
					nxt.focus_left = cur_psecs;
					accepted       = 1'b1;
				end
			end
			CMD_START_BREAK: begin
				if (cur.mode == MODE_PROMPT) begin
					nxt.break_left = brk_secs;
					nxt.deadline   = new_dl;
					nxt.mode       = MODE_BRUN;
					accepted       = 1'b1;
				end
			end
			CMD_SKIP_BREAK: begin
				if (cur.mode == MODE_PROMPT) begin
					nxt.mode       = MODE_IDLE;
					nxt.break_left = 11'd0;
					nxt.focus_left = cur_psecs;
					accepted       = 1'b1;
				end
			end
			default: begin
				accepted = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/focus_break_interval_timer.sv =====
// Focus/break interval timer. Each request on the input stream carries a command and the
// current millisecond time; each one yields exactly one result with the accepted flag, a
// timeout event (ticks only) and a snapshot of mode, remaining focus and break seconds,
// preset, next break length, round and session counts. One request is taken every clock
// cycle unless the result register is full and not drained; a request passes the input
// register, then the result register, whose output is its result, and the whole state
// update of a request is done combinationally between them, including the ceiling divide
// by 1000 of the time left. The two window registers sit on the APB port at byte 0 (confirm
// window) and byte 4 (reward window) and should only be written while no request is in flight.
`default_nettype none

module focus_break_interval_timer import fbit_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // [3:0] cmd, [51:4] now_ms, [55:52] zero
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [0] accepted, [3:1] event_res, [6:4] mode,
	                                    // [19:7] focus_left_sec, [30:20] break_left_sec,
	                                    // [34:31] preset_index, [39:35] next_break_min,
	                                    // [41:40] round_count, [73:42] session_count,
	                                    // [79:74] zero
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic        valid_s1;
	logic [3:0]  cmd_s1;
	logic [47:0] now_s1;
	logic        out_valid_q;
	logic [79:0] out_data_q;
	logic [15:0] confirm_win_q;
	logic [15:0] reward_win_q;
	fbit_state_t state_q;
	fbit_state_t state_nxt;
	logic        acc;
	logic [2:0]  ev;
	logic        advance;

	// Configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_win_q <= CONFIRM_WIN_RESET;
			reward_win_q  <= REWARD_WIN_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_CONFIRM_WIN) begin
				confirm_win_q <= pwdata[15:0];
			end else begin
				reward_win_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = {16'd0, (paddr[2] == REG_CONFIRM_WIN) ? confirm_win_q : reward_win_q};

	// Advance when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= s_tdata[3:0];
			now_s1 <= s_tdata[51:4];
		end
	end

	fbit_step u_step (
		.cur         (state_q),
		.cmd         (cmd_s1),
		.now_ms      (now_s1),
		.confirm_win (confirm_win_q),
		.reward_win  (reward_win_q),
		.nxt         (state_nxt),
		.accepted    (acc),
		.event_res   (ev)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {6'd0, state_nxt.session, state_nxt.round, state_nxt.break_min,
				state_nxt.preset, state_nxt.break_left, state_nxt.focus_left,
				state_nxt.mode, ev, acc};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Hold state unless a request moves into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a request");

	// A request that moves on always leaves a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("request advanced but no result is pending");

	// A stuck input register blocks new requests
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !s_tready)
		else $error("request taken while input register is stuck");

	// Remaining seconds stay within their caps
	a_caps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.focus_left <= 13'(FOCUS_CAP)) && (state_q.break_left <= 11'(BREAK_CAP)))
		else $error("remaining seconds beyond cap");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import fbit_pkg::*;

	// One status result as the block reports it
	typedef struct packed {
		logic        accepted;
		event_t      ev;
		mode_t       mode;
		logic [12:0] focus_left;
		logic [10:0] break_left;
		logic [3:0]  preset;
		logic [4:0]  break_min;
		logic [1:0]  round;
		logic [31:0] session;
	} status_t;

	// Directed row: command, time, and a typed status where one is given
	typedef struct packed {
		logic [3:0]  cmd;
		logic [47:0] now;
		logic        typed;
		status_t     want;
	} plan_row_t;

	localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam logic [3:0]  CMD_UNKNOWN = 4'd15;
	localparam logic [2:0]  ADDR_CONFIRM_WIN = {REG_CONFIRM_WIN, 2'b00};
	localparam logic [2:0]  ADDR_REWARD_WIN  = {REG_REWARD_WIN, 2'b00};

	localparam status_t IDLE_AFTER_RESET = '{
		accepted: 1'b1, ev: EV_NONE, mode: MODE_IDLE, focus_left: 13'd1500,
		break_left: 11'd0, preset: 4'd4, break_min: 5'd5, round: 2'd0, session: 32'd0
	};
	localparam status_t REJECT_AFTER_RESET = '{
		accepted: 1'b0, ev: EV_NONE, mode: MODE_IDLE, focus_left: 13'd1500,
		break_left: 11'd0, preset: 4'd4, break_min: 5'd5, round: 2'd0, session: 32'd0
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [55:0] s_tdata = '0;     // [3:0] cmd, [51:4] now_ms, [55:52] zero
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [79:0] m_tdata;          // [0] accepted, [3:1] event_res, [6:4] mode,
	                               // [19:7] focus_left_sec, [30:20] break_left_sec,
	                               // [34:31] preset_index, [39:35] next_break_min,
	                               // [41:40] round_count, [73:42] session_count
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	// Timer state as predicted
	mode_t       st_mode = MODE_IDLE;
	logic [3:0]  st_preset = 4'd4;
	logic [12:0] st_focus = 13'd1500;
	logic [10:0] st_break = 11'd0;
	logic [4:0]  st_break_min = 5'd5;
	logic [1:0]  st_round = 2'd0;
	logic [31:0] st_session = 32'd0;
	logic [47:0] st_run_dl = '0;
	logic [47:0] st_confirm_dl = '0;
	logic [47:0] st_reward_dl = '0;
	logic [15:0] confirm_win = 16'd5000;
	logic [15:0] reward_win = 16'd3000;

	status_t     expected_status [$];
	logic [63:0] clock_ms = '0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          fail_count = 0;
	int          n_requests = 0;
	int          n_accepted = 0;
	int          n_focus_done = 0;
	int          n_reward_done = 0;
	int          n_break_done = 0;
	int          n_timeouts = 0;

	plan_row_t directed_plan [27] = '{
		'{CMD_TICK,        48'd0,              1'b1, IDLE_AFTER_RESET},
		'{CMD_UNKNOWN,     48'd0,              1'b1, REJECT_AFTER_RESET},
		'{CMD_NEXT_PRESET, 48'd0,              1'b0, '0},
		'{CMD_NEXT_PRESET, 48'd0,              1'b0, '0},
		'{CMD_NEXT_PRESET, 48'd0,              1'b0, '0},
		'{CMD_NEXT_PRESET, 48'd0,              1'b0, '0},
		'{CMD_NEXT_PRESET, 48'd0,              1'b0, '0},
		'{CMD_PREV_PRESET, 48'd0,              1'b0, '0},
		'{CMD_START_FOCUS, TIME_MAX - 48'd1000, 1'b0, '0},
		'{CMD_TICK,        TIME_MAX,           1'b0, '0},
		'{CMD_TICK,        TIME_MAX,           1'b0, '0},
		'{CMD_START_BREAK, 48'd5000000,        1'b0, '0},
		'{CMD_PAUSE,       48'd0,              1'b0, '0},
		'{CMD_RESUME,      48'd10,             1'b0, '0},
		'{CMD_TICK,        48'd1800010,        1'b0, '0},
		'{CMD_START_FOCUS, 48'd1000,           1'b0, '0},
		'{CMD_PAUSE,       48'd0,              1'b0, '0},
		'{CMD_REQ_ABANDON, 48'd2000,           1'b0, '0},
		'{CMD_TICK,        48'd7000,           1'b0, '0},
		'{CMD_REQ_ABANDON, 48'd8000,           1'b0, '0},
		'{CMD_CANCEL_AB,   48'd8001,           1'b0, '0},
		'{CMD_RESUME,      48'd10000,          1'b0, '0},
		'{CMD_PAUSE,       48'd6000000,        1'b0, '0},
		'{CMD_RESUME,      48'd6000001,        1'b0, '0},
		'{CMD_REQ_ABANDON, 48'd6000002,        1'b0, '0},
		'{CMD_CONFIRM_AB,  48'd6000003,        1'b0, '0},
		'{CMD_SKIP_BREAK,  48'd6000004,        1'b0, '0}
	};

	focus_break_interval_timer dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic int unsigned preset_minutes(input logic [3:0] idx);
		logic [3:0] i;
		i = (idx >= PRESET_COUNT) ? 4'(DEFAULT_PRESET) : idx;
		case (i)
			4'd0: return 5;
			4'd1: return 10;
			4'd2: return 15;
			4'd3: return 20;
			4'd4: return 25;
			4'd5: return 30;
			4'd6: return 45;
			4'd7: return 60;
			default: return 90;
		endcase
	endfunction

	// Absolute deadline, clamped at the top of the 48-bit time range
	function automatic logic [47:0] sat_deadline(input logic [47:0] now, input logic [63:0] dur);
		logic [63:0] s;
		s = 64'(now) + dur;
		return (s > 64'(TIME_MAX)) ? TIME_MAX : s[47:0];
	endfunction

	// Whole seconds left, rounded up and capped
	function automatic logic [12:0] secs_left(input logic [47:0] dl, input logic [47:0] now,
			input int unsigned cap);
		logic [63:0] q;
		if (now >= dl)
			return '0;
		q = (64'(dl) - 64'(now) + CEIL_ADJ) / MS_PER_SEC;
		return (q > cap) ? 13'(cap) : 13'(q);
	endfunction

	function automatic void refresh_running(input logic [47:0] now);
		if (st_mode == MODE_FRUN)
			st_focus = secs_left(st_run_dl, now, FOCUS_CAP);
		else if (st_mode == MODE_BRUN)
			st_break = 11'(secs_left(st_run_dl, now, BREAK_CAP));
	endfunction

	// Advance the predicted timer by one command and report its status
	function automatic status_t apply_command(input logic [3:0] cmd, input logic [47:0] now);
		logic        ok;
		event_t      ev;
		int unsigned f;
		ok = 1'b0;
		ev = EV_NONE;
		case (cmd)
			CMD_TICK: begin
				ok = 1'b1;
				refresh_running(now);
				if (st_mode == MODE_FRUN && st_focus == 0) begin
					f = preset_minutes(st_preset);
					st_break_min = (f >= 60) ? 5'd15 : ((f >= 30) ? 5'd10 : 5'd5);
					if (st_round == 2'd3)
						st_break_min = st_break_min << 1;
					st_round = st_round + 2'd1;
					st_mode = MODE_REWARD;
					st_run_dl = '0;
					st_reward_dl = sat_deadline(now, 64'(reward_win));
					ev = EV_FOCUS_DONE;
				end else if (st_mode == MODE_REWARD && now >= st_reward_dl) begin
					st_mode = MODE_PROMPT;
					st_reward_dl = '0;
					ev = EV_REWARD_DONE;
				end else if (st_mode == MODE_BRUN && st_break == 0) begin
					st_mode = MODE_IDLE;
					st_focus = 13'(preset_minutes(st_preset) * SEC_PER_MIN);
					st_run_dl = '0;
					ev = EV_BREAK_DONE;
				end else if (st_mode == MODE_CONFIRM && now >= st_confirm_dl) begin
					st_mode = MODE_FPAUSE;
					st_confirm_dl = '0;
					ev = EV_CONFIRM_TIMEOUT;
				end
			end
			CMD_NEXT_PRESET, CMD_PREV_PRESET: begin
				if (st_mode == MODE_IDLE) begin
					if (cmd == CMD_NEXT_PRESET)
						st_preset = (st_preset + 1 >= PRESET_COUNT) ? 4'd0 : st_preset + 4'd1;
					else
						st_preset = (st_preset == 0) ? 4'(PRESET_COUNT - 1) : st_preset - 4'd1;
					st_focus = 13'(preset_minutes(st_preset) * SEC_PER_MIN);
					ok = 1'b1;
				end
			end
			CMD_START_FOCUS: begin
				if (st_mode == MODE_IDLE) begin
					st_focus = 13'(preset_minutes(st_preset) * SEC_PER_MIN);
					st_session = st_session + 32'd1;
					st_run_dl = sat_deadline(now, 64'(st_focus) * MS_PER_SEC);
					st_mode = MODE_FRUN;
					ok = 1'b1;
				end
			end
			CMD_PAUSE: begin
				refresh_running(now);
				if (st_mode == MODE_FRUN || st_mode == MODE_BRUN) begin
					if (st_mode == MODE_FRUN)
						st_mode = MODE_FPAUSE;
					else
						st_mode = MODE_BPAUSE;
					st_run_dl = '0;
					ok = 1'b1;
				end
			end
			CMD_RESUME: begin
				if (st_mode == MODE_FPAUSE && st_focus > 0) begin
					st_mode = MODE_FRUN;
					st_run_dl = sat_deadline(now, 64'(st_focus) * MS_PER_SEC);
					ok = 1'b1;
				end else if (st_mode == MODE_BPAUSE && st_break > 0) begin
					st_mode = MODE_BRUN;
					st_run_dl = sat_deadline(now, 64'(st_break) * MS_PER_SEC);
					ok = 1'b1;
				end
			end
			CMD_REQ_ABANDON: begin
				if (st_mode == MODE_FPAUSE) begin
					st_mode = MODE_CONFIRM;
					st_confirm_dl = sat_deadline(now, 64'(confirm_win));
					ok = 1'b1;
				end
			end
			CMD_CANCEL_AB, CMD_CONFIRM_AB: begin
				if (st_mode == MODE_CONFIRM) begin
					if (cmd == CMD_CANCEL_AB) begin
						st_mode = MODE_FPAUSE;
					end else begin
						st_mode = MODE_IDLE;
						st_focus = 13'(preset_minutes(st_preset) * SEC_PER_MIN);
					end
					st_confirm_dl = '0;
					ok = 1'b1;
				end
			end
			CMD_START_BREAK: begin
				if (st_mode == MODE_PROMPT) begin
					st_break = 11'(st_break_min * SEC_PER_MIN);
					st_run_dl = sat_deadline(now, 64'(st_break) * MS_PER_SEC);
					st_mode = MODE_BRUN;
					ok = 1'b1;
				end
			end
			CMD_SKIP_BREAK: begin
				if (st_mode == MODE_PROMPT) begin
					st_mode = MODE_IDLE;
					st_break = '0;
					st_focus = 13'(preset_minutes(st_preset) * SEC_PER_MIN);
					ok = 1'b1;
				end
			end
			default: ;
		endcase
		return '{accepted: ok, ev: ev, mode: st_mode, focus_left: st_focus,
			break_left: st_break, preset: st_preset, break_min: st_break_min,
			round: st_round, session: st_session};
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each result with the oldest outstanding status
	always @(posedge clk) begin : check_results
		status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_status.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = expected_status.pop_front();
				check_field("accepted", want.accepted, m_tdata[0]);
				check_field("event_res", want.ev, m_tdata[3:1]);
				check_field("mode", want.mode, m_tdata[6:4]);
				check_field("focus_left_sec", want.focus_left, m_tdata[19:7]);
				check_field("break_left_sec", want.break_left, m_tdata[30:20]);
				check_field("preset_index", want.preset, m_tdata[34:31]);
				check_field("next_break_min", want.break_min, m_tdata[39:35]);
				check_field("round_count", want.round, m_tdata[41:40]);
				check_field("session_count", want.session, m_tdata[73:42]);
			end
		end
	end

	// Send one request, idling first at random, and record its status
	task automatic send_request(input logic [3:0] cmd, input logic [47:0] now,
			input logic typed, input status_t want);
		status_t snap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, now, cmd};
		do @(posedge clk); while (!s_tready);
		snap = apply_command(cmd, now);
		expected_status.push_back(typed ? want : snap);
		n_requests++;
		if (snap.accepted)
			n_accepted++;
		case (snap.ev)
			EV_FOCUS_DONE:      n_focus_done++;
			EV_REWARD_DONE:     n_reward_done++;
			EV_BREAK_DONE:      n_break_done++;
			EV_CONFIRM_TIMEOUT: n_timeouts++;
			default: ;
		endcase
	endtask

	// Hold off the sender until every outstanding result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		for (int i = 0; i < 20000 && expected_status.size() != 0; i++)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB transfer; a read is checked against data
	task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wr ? data : 32'd0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr)
			check_field("prdata", data, prdata);
	endtask

	task automatic write_windows(input logic [15:0] confirm_ms, input logic [15:0] reward_ms);
		apb_xfer(1'b1, ADDR_CONFIRM_WIN, 32'(confirm_ms));
		apb_xfer(1'b1, ADDR_REWARD_WIN, 32'(reward_ms));
		apb_xfer(1'b0, ADDR_CONFIRM_WIN, 32'(confirm_ms));
		apb_xfer(1'b0, ADDR_REWARD_WIN, 32'(reward_ms));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		confirm_win = confirm_ms;
		reward_win = reward_ms;
	endtask

	// Pick a command that mostly follows the current mode, with a time step
	task automatic pick_request(output logic [3:0] cmd, output logic [47:0] now);
		int unsigned r;
		int unsigned off;
		int unsigned back;
		logic [63:0] target;
		case (st_mode)
			MODE_FRUN, MODE_BRUN: target = 64'(st_run_dl);
			MODE_CONFIRM:         target = 64'(st_confirm_dl);
			MODE_REWARD:          target = 64'(st_reward_dl);
			default:              target = clock_ms;
		endcase

		// Advance time a little or far, jump near the live deadline, or go backwards
		r = $urandom_range(0, 99);
		if (r < 35) begin
			clock_ms = clock_ms + $urandom_range(0, 2000);
		end else if (r < 65) begin
			off = $urandom_range(0, 3000);
			clock_ms = (target + off < 1500) ? 64'd0 : target + off - 1500;
		end else if (r < 85) begin
			clock_ms = clock_ms + $urandom_range(0, 900000);
		end else begin
			back = $urandom_range(0, 7000000);
			clock_ms = (clock_ms > back) ? clock_ms - back : 64'd0;
		end
		if (clock_ms > 64'(TIME_MAX))
			clock_ms = 64'(TIME_MAX);
		now = clock_ms[47:0];

		r = $urandom_range(0, 99);
		if (r < 10) begin
			cmd = 4'($urandom_range(0, 15));
		end else begin
			r = $urandom_range(0, 99);
			case (st_mode)
				MODE_IDLE: begin
					if (r < 25)
						cmd = $urandom_range(0, 1) ? CMD_NEXT_PRESET : CMD_PREV_PRESET;
					else if (r < 35)
						cmd = CMD_TICK;
					else
						cmd = CMD_START_FOCUS;
				end
				MODE_FRUN:    cmd = (r < 70) ? CMD_TICK : CMD_PAUSE;
				MODE_FPAUSE: begin
					if (r < 45)
						cmd = CMD_RESUME;
					else if (r < 85)
						cmd = CMD_REQ_ABANDON;
					else
						cmd = CMD_TICK;
				end
				MODE_CONFIRM: begin
					if (r < 30)
						cmd = CMD_CANCEL_AB;
					else if (r < 50)
						cmd = CMD_CONFIRM_AB;
					else
						cmd = CMD_TICK;
				end
				MODE_REWARD:  cmd = (r < 90) ? CMD_TICK : CMD_PAUSE;
				MODE_PROMPT: begin
					if (r < 65)
						cmd = CMD_START_BREAK;
					else if (r < 90)
						cmd = CMD_SKIP_BREAK;
					else
						cmd = CMD_TICK;
				end
				MODE_BRUN:    cmd = (r < 75) ? CMD_TICK : CMD_PAUSE;
				default:      cmd = (r < 85) ? CMD_RESUME : CMD_TICK;
			endcase
		end
	endtask

	initial begin
		logic [3:0]  cmd;
		logic [47:0] now;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Windows read back their reset values
		apb_xfer(1'b0, ADDR_CONFIRM_WIN, 32'd5000);
		apb_xfer(1'b0, ADDR_REWARD_WIN, 32'd3000);
		psel <= 1'b0;
		penable <= 1'b0;

		// Walk the directed plan
		send_idle_pct = 23;
		recv_stall_pct = 52;
		foreach (directed_plan[i])
			send_request(directed_plan[i].cmd, directed_plan[i].now, directed_plan[i].typed,
				directed_plan[i].want);
		drain_results();

		// Random phases, each under its own window setting and one of three idling patterns
		for (int p = 0; p < 8; p++) begin
			if (p < 3) begin
				send_idle_pct = 23;
				recv_stall_pct = 52;
			end else if (p < 6) begin
				send_idle_pct = 52;
				recv_stall_pct = 23;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			case (p)
				0: write_windows(16'd0, 16'd0);
				1: write_windows(16'hFFFF, 16'hFFFF);
				2: write_windows(16'd1, 16'hFFFF);
				3: write_windows(16'hFFFF, 16'd0);
				6: write_windows(16'd5000, 16'd3000);
				default: write_windows(16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
			endcase
			case (p % 4)
				0: clock_ms = 64'($urandom_range(0, 100000));
				3: clock_ms = 64'(TIME_MAX) - $urandom_range(0, 20000000);
				default: clock_ms = {$urandom, $urandom} & 64'(TIME_MAX);
			endcase
			repeat (210) begin
				pick_request(cmd, now);
				send_request(cmd, now, 1'b0, '0);
			end
			drain_results();
		end

		if (expected_status.size() != 0) begin
			$error("%0d results never arrived", expected_status.size());
			fail_count++;
		end
		$display("Ran %0d commands (%0d accepted) over 8 window settings and 3 idling patterns.",
			n_requests, n_accepted);
		$display("Events: %0d focus done, %0d reward done, %0d break done, %0d confirm timeouts.",
			n_focus_done, n_reward_done, n_break_done, n_timeouts);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
